@@ rtl/core/itcv_pkg.sv @@
// Shared constants, types and CRC function for the info table checksum validator.
`timescale 1ns / 1ps

package itcv_pkg;

  localparam int unsigned MAX_TABLE_BYTES = 65536;
  localparam int COUNT_W   = $clog2(MAX_TABLE_BYTES + 1);
  localparam int LEN_BYTES = (COUNT_W + 7) / 8;

  localparam logic [31:0] VERSION_ONE = 32'h4849_0100;
  localparam logic [31:0] VERSION_TWO = 32'h4849_0200;
  localparam logic [31:0] CRC_POLY    = 32'h04C1_1DB7;

  localparam int IN_TDATA_W    = 8;
  localparam int OUT_PAYLOAD_W = 2 + 32 + 32 + 32;
  localparam int OUT_TDATA_W   = ((OUT_PAYLOAD_W + 7) / 8) * 8;

  typedef logic [COUNT_W-1:0] count_t;

  typedef enum logic [1:0] {
    ST_OK           = 2'd0,
    ST_BAD_VERSION  = 2'd1,
    ST_SIZE_ERR     = 2'd2,
    ST_CRC_MISMATCH = 2'd3
  } status_t;

  // Buffer state as it stands after its last byte.
  typedef struct packed {
    logic [31:0] version;
    logic [31:0] size;
    count_t      count;
    logic [31:0] crc;
    logic [31:0] stored;
  } snap_t;

  // MSB-first CRC-32 over one byte.
  function automatic logic [31:0] crc_byte(input logic [31:0] crc, input logic [7:0] b);
    logic [31:0] c;
    c = crc ^ {b, 24'h000000};
    for (int k = 0; k < 8; k++) begin
      c = c[31] ? ((c << 1) ^ CRC_POLY) : (c << 1);
    end
    return c;
  endfunction

endpackage

@@ rtl/core/info_table_cksum_validator.sv @@
// Top level: streaming info table checksum validator.
`timescale 1ns / 1ps

// Throughput: one byte transaction per cycle, sustained; the input stalls only while a
//   finished buffer result is blocked at the output behind an earlier one.
// Path: the last byte goes through the input register, then the buffer snapshot register,
//   then the result register, which holds the valid result.
// Reset: synchronous, active high; clears all valid flags and the buffer state.
module info_table_cksum_validator (
  input  logic                                clk,
  input  logic                                rst,
  // slave side
  input  logic                                s_tvalid,
  output logic                                s_tready,
  input  logic [itcv_pkg::IN_TDATA_W-1:0]     s_tdata,   // [7:0] data_byte
  input  logic                                s_tlast,   // last_byte
  // master side
  output logic                                m_tvalid,
  input  logic                                m_tready,
  // [1:0] status, [33:2] computed_crc, [65:34] stored_crc,
  // [97:66] table_version, upper bits zero
  output logic [itcv_pkg::OUT_TDATA_W-1:0]    m_tdata
);

  // Stage 1: registered input byte
  logic       s1_valid;
  logic [7:0] s1_byte;
  logic       s1_last;
  logic       s1_go, s1_free;

  // Stage 2: snapshot of a completed buffer
  logic              s2_valid;
  itcv_pkg::snap_t   snap, snap_q;
  logic              s2_free, out_free;

  // Result register
  itcv_pkg::status_t status_q, status_c;
  logic [31:0]       computed_q, computed_c;
  logic [31:0]       stored_q, version_q;

  // Length extension
  itcv_pkg::count_t                   len;
  logic [itcv_pkg::LEN_BYTES*8-1:0]   len_ext;
  logic [31:0]                        ext_crc, inv_crc;

  assign out_free = !m_tvalid || m_tready;
  assign s2_free  = !s2_valid || out_free;
  // a non-last byte never waits; a last byte waits for a free snapshot slot
  assign s1_go    = s1_valid && (!s1_last || s2_free);
  assign s1_free  = !s1_valid || s1_go;
  assign s_tready = s1_free;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (s1_free) begin
      s1_valid <= s_tvalid;
    end
    if (s1_free) begin
      s1_byte <= s_tdata[7:0];
      s1_last <= s_tlast;
    end
  end

  itcv_tracker u_tracker (
    .clk       (clk),
    .rst       (rst),
    .step      (s1_go),
    .data_byte (s1_byte),
    .last_byte (s1_last),
    .snap      (snap)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
    end else if (s2_free) begin
      s2_valid <= s1_go && s1_last;
    end
    if (s2_free && s1_go && s1_last) begin
      snap_q <= snap;
    end
  end

  // Final checks: version, then size, then CRC with the length folded in
  // low byte first, skipping once the remaining length is zero.
  always_comb begin
    len     = snap_q.size[itcv_pkg::COUNT_W-1:0] - itcv_pkg::count_t'(4);
    len_ext = (itcv_pkg::LEN_BYTES*8)'(len);
    ext_crc = snap_q.crc;
    for (int i = 0; i < itcv_pkg::LEN_BYTES; i++) begin
      if ((len_ext >> (8 * i)) != '0) begin
        ext_crc = itcv_pkg::crc_byte(ext_crc, len_ext[8*i +: 8]);
      end
    end
    inv_crc = ~ext_crc;
    priority if (snap_q.version != itcv_pkg::VERSION_ONE &&
                 snap_q.version != itcv_pkg::VERSION_TWO) begin
      status_c   = itcv_pkg::ST_BAD_VERSION;
      computed_c = '0;
    end else if (snap_q.size < 32'd8 || snap_q.size > 32'(snap_q.count)) begin
      status_c   = itcv_pkg::ST_SIZE_ERR;
      computed_c = '0;
    end else begin
      status_c   = (inv_crc == snap_q.stored) ? itcv_pkg::ST_OK : itcv_pkg::ST_CRC_MISMATCH;
      computed_c = inv_crc;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (out_free) begin
      m_tvalid <= s2_valid;
    end
    if (out_free && s2_valid) begin
      status_q   <= status_c;
      computed_q <= computed_c;
      stored_q   <= snap_q.stored;
      version_q  <= snap_q.version;
    end
  end

  assign m_tdata = {(itcv_pkg::OUT_TDATA_W - itcv_pkg::OUT_PAYLOAD_W)'(0),
                    version_q, stored_q, computed_q, status_q};

  // The input only stalls behind a last byte waiting for the snapshot slot.
  a_stall_only_on_last: assert property (@(posedge clk) disable iff (rst)
    !s_tready |-> (s1_valid && s1_last && s2_valid))
    else $error("input stalled without a blocked buffer end");

  // A good status means the two CRC words agree.
  a_ok_match: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && status_q == itcv_pkg::ST_OK) |-> (computed_q == stored_q))
    else $error("valid status with mismatching CRC");

  // Header errors carry no computed CRC.
  a_err_zero_crc: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && (status_q == itcv_pkg::ST_BAD_VERSION ||
                  status_q == itcv_pkg::ST_SIZE_ERR)) |-> (computed_q == 32'd0))
    else $error("nonzero CRC reported on header error");

  // A new result only appears after a snapshot was taken.
  a_result_source: assert property (@(posedge clk) disable iff (rst)
    $rose(m_tvalid) |-> $past(s2_valid))
    else $error("result without a buffer snapshot");

endmodule

@@ rtl/core/itcv_tracker.sv @@
// Per-buffer state: header capture, running CRC and stored-CRC capture.
`timescale 1ns / 1ps

module itcv_tracker (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 step,
  input  logic [7:0]           data_byte,
  input  logic                 last_byte,
  output itcv_pkg::snap_t      snap
);

  itcv_pkg::count_t byte_count, cnt_next;
  logic [31:0] version_word, ver_next;
  logic [31:0] table_size, size_next;
  logic [31:0] crc_accum, crc_next;
  logic [31:0] stored_word, stored_next;
  logic [31:0] pos32, body, body_hdr;

  function automatic logic [31:0] lane_or(input logic [31:0] w, input logic [7:0] b,
                                          input logic [31:0] diff);
    logic [1:0] l;
    l = diff[1:0];
    return w | (32'(b) << {l, 3'b000});
  endfunction

  always_comb begin
    cnt_next    = byte_count;
    ver_next    = version_word;
    size_next   = table_size;
    crc_next    = crc_accum;
    stored_next = stored_word;
    pos32       = 32'(byte_count);
    body        = table_size - 32'd4;
    body_hdr    = 32'd0;
    if (byte_count < itcv_pkg::count_t'(itcv_pkg::MAX_TABLE_BYTES)) begin
      cnt_next = byte_count + itcv_pkg::count_t'(1);
      if (pos32 < 32'd4) begin
        ver_next = version_word | (32'(data_byte) << {byte_count[1:0], 3'b000});
        crc_next = itcv_pkg::crc_byte(crc_accum, data_byte);
      end else if (pos32 < 32'd8) begin
        size_next = table_size | (32'(data_byte) << {byte_count[1:0], 3'b000});
        // size word complete: fold its own bytes into the CRC or the stored word now
        if (pos32 == 32'd7 && size_next >= 32'd8) begin
          body_hdr = size_next - 32'd4;
          for (int q = 4; q < 8; q++) begin
            if (32'(q) < body_hdr) begin
              crc_next = itcv_pkg::crc_byte(crc_next, size_next[(q-4)*8 +: 8]);
            end else begin
              stored_next = lane_or(stored_next, size_next[(q-4)*8 +: 8],
                                    32'(q) - body_hdr);
            end
          end
        end
      end else if (table_size >= 32'd8) begin
        if (pos32 < body) begin
          crc_next = itcv_pkg::crc_byte(crc_accum, data_byte);
        end else if (pos32 - body < 32'd4) begin
          stored_next = lane_or(stored_word, data_byte, pos32 - body);
        end
      end
    end
  end

  assign snap = '{version: ver_next, size: size_next, count: cnt_next,
                  crc: crc_next, stored: stored_next};

  always_ff @(posedge clk) begin
    if (rst || (step && last_byte)) begin
      byte_count   <= '0;
      version_word <= '0;
      table_size   <= '0;
      crc_accum    <= '0;
      stored_word  <= '0;
    end else if (step) begin
      byte_count   <= cnt_next;
      version_word <= ver_next;
      table_size   <= size_next;
      crc_accum    <= crc_next;
      stored_word  <= stored_next;
    end
  end

endmodule
